>>> design/swap_pkg.sv
`timescale 1ns / 1ps
// shared constants, register indexes and command type for the sliding window power block
package swap_pkg;

    // sizing
    localparam int WINDOW_MAX  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int SUM_W       = PROD_W + SLOT_W;

    // configuration registers
    localparam int LEN_W     = 11;
    localparam int INV_W     = 25;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic [LEN_W-1:0] WIN_RESET = LEN_W'(256);
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WINDOW    = 1'b1;

    // scaling: the sum is split into a low unsigned half and a high signed half
    localparam int FRAC_W = 24;
    localparam int OUT_W  = 32;
    localparam int LO_W   = SUM_W / 2;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int MA_W   = INV_W + 1;
    localparam int MB_W   = HI_W + 1;
    localparam int MUL_W  = MA_W + MB_W;
    localparam int TOT_W  = MUL_W + LO_W;

    typedef struct packed {
        logic accept;    // take the request, form the product, read the ring
        logic acc;       // write the ring, update sum and counters
        logic mul_lo;    // low half of sum times reciprocal
        logic mul_hi;    // high half of sum times reciprocal
        logic load_out;  // combine, saturate, load result register
    } dp_cmd_t;

endpackage

>>> design/swap_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences one request through the datapath and owns both handshakes
module swap_ctrl
    import swap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_MLO  = 3'd2;
    localparam logic [2:0] ST_MHI  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = in_valid && (state_reg == ST_IDLE);
        cmd.acc      = (state_reg == ST_ACC);
        cmd.mul_lo   = (state_reg == ST_MLO);
        cmd.mul_hi   = (state_reg == ST_MHI);
        cmd.load_out = (state_reg == ST_OUT) && out_free;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:  state_next = ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/swap_datapath.sv
`timescale 1ns / 1ps
// datapath: product ring, running sum, counters, shared multiplier and result registers
module swap_datapath
    import swap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic signed [15:0]      current_sample,
    input  logic signed [15:0]      voltage_sample,
    input  logic                    restart,
    output logic signed [OUT_W-1:0] average_power,
    output logic                    window_full
);

    // configuration and window state
    logic [LEN_W-1:0]        win_len_reg;
    logic [INV_W-1:0]        inv_reg;
    logic [SLOT_W-1:0]       write_slot_reg;
    logic [SLOT_W-1:0]       write_slot_next;
    logic [CNT_W-1:0]        high_water_reg;
    logic [CNT_W-1:0]        high_water_next;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    // per-request payload
    logic [SLOT_W-1:0]        slot_reg;
    logic                     old_ok_reg;
    logic                     restart_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] rd_data_reg;
    logic signed [MUL_W-1:0]  pp_lo_reg;
    logic signed [MUL_W-1:0]  pp_hi_reg;
    logic                     full_calc_reg;
    logic                     full_calc_next;
    logic signed [OUT_W-1:0]  avg_out_reg;
    logic                     full_out_reg;

    logic signed [PROD_W-1:0] ring_mem [WINDOW_MAX];

    logic [CNT_W-1:0]         len_eff;
    logic [SLOT_W-1:0]        slot_addr;
    logic                     old_ok_next;
    logic [CNT_W-1:0]         slot_inc;
    logic [CNT_W-1:0]         hw_base;
    logic [CNT_W-1:0]         fill_base;
    logic signed [SUM_W-1:0]  sum_base;
    logic signed [PROD_W-1:0] old_val;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MUL_W-1:0]  mul_res;
    logic signed [TOT_W-1:0]  total;
    logic [TOT_W-FRAC_W-OUT_W:0] top_bits;
    logic signed [OUT_W-1:0]  avg_sat;

    // window length clamped to 1..WINDOW_MAX
    always_comb
    begin
        priority if (win_len_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (CMP_W'(win_len_reg) > CMP_W'(WINDOW_MAX))
        begin
            len_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = CNT_W'(win_len_reg);
        end
    end

    // slot for this sample; slots written since restart form a prefix below the high water mark
    assign slot_addr   = (restart || ({1'b0, write_slot_reg} >= len_eff)) ? '0 : write_slot_reg;
    assign old_ok_next = !restart && ({1'b0, slot_addr} < high_water_reg);

    assign slot_inc  = {1'b0, slot_reg} + CNT_W'(1);
    assign hw_base   = restart_reg ? '0 : high_water_reg;
    assign fill_base = restart_reg ? '0 : fill_reg;
    assign sum_base  = restart_reg ? '0 : sum_reg;
    assign old_val   = old_ok_reg ? rd_data_reg : '0;

    assign sum_next        = sum_base - SUM_W'(old_val) + SUM_W'(product_reg);
    assign write_slot_next = (slot_inc >= len_eff) ? '0 : slot_inc[SLOT_W-1:0];
    assign high_water_next = (slot_inc > hw_base) ? slot_inc : hw_base;
    assign fill_next       = (fill_base < CNT_W'(WINDOW_MAX)) ? fill_base + CNT_W'(1) : fill_base;
    assign full_calc_next  = (fill_next >= len_eff);

    // one signed multiplier shared by the product and both scaling halves
    always_comb
    begin
        priority if (cmd.mul_lo)
        begin
            mul_a = MA_W'(inv_reg);
            mul_b = MB_W'(sum_reg[LO_W-1:0]);
        end
        else if (cmd.mul_hi)
        begin
            mul_a = MA_W'(inv_reg);
            mul_b = MB_W'(signed'(sum_reg[SUM_W-1:LO_W]));
        end
        else
        begin
            mul_a = MA_W'(signed'(current_sample[SAMPLE_BITS-1:0]));
            mul_b = MB_W'(signed'(voltage_sample[SAMPLE_BITS-1:0]));
        end
    end

    assign mul_res = mul_a * mul_b;

    // recombine halves, floor shift, saturate
    assign total    = (TOT_W'(pp_hi_reg) <<< LO_W) + TOT_W'(pp_lo_reg);
    assign top_bits = total[TOT_W-1:FRAC_W+OUT_W-1];

    always_comb
    begin
        priority if ((&top_bits) || !(|top_bits))
        begin
            avg_sat = total[FRAC_W+OUT_W-1:FRAC_W];
        end
        else if (total[TOT_W-1])
        begin
            avg_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            avg_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg    <= WIN_RESET;
            inv_reg        <= INV_RESET;
            write_slot_reg <= '0;
            high_water_reg <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH: win_len_reg <= cfg_data[LEN_W-1:0];
                    REG_INV_WINDOW:    inv_reg     <= cfg_data[INV_W-1:0];
                    default:           ;
                endcase
            end
            if (cmd.acc)
            begin
                write_slot_reg <= write_slot_next;
                high_water_reg <= high_water_next;
                fill_reg       <= fill_next;
                sum_reg        <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg    <= slot_addr;
            old_ok_reg  <= old_ok_next;
            restart_reg <= restart;
            product_reg <= mul_res[PROD_W-1:0];
        end
        if (cmd.acc)
        begin
            full_calc_reg <= full_calc_next;
        end
        if (cmd.mul_lo)
        begin
            pp_lo_reg <= mul_res;
        end
        if (cmd.mul_hi)
        begin
            pp_hi_reg <= mul_res;
        end
        if (cmd.load_out)
        begin
            avg_out_reg  <= avg_sat;
            full_out_reg <= full_calc_reg;
        end
    end

    // product ring: read at request time, written in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            ring_mem[slot_reg] <= product_reg;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= ring_mem[slot_addr];
        end
    end

    assign average_power = avg_out_reg;
    assign window_full   = full_out_reg;

endmodule

>>> design/sliding_window_active_power.sv
`timescale 1ns / 1ps
// top level of the sliding window active power averager
//
// usage
// - input channel (in_valid / in_ready): one request carries a signed current and voltage
//   sample plus a restart flag; restart empties the window before the sample enters
// - output channel (out_valid / out_ready): one result per request, the windowed power sum
//   times the Q24 reciprocal inv_window, floored and saturated to 32 bits, plus window_full
// - config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 writes
//   window_length, index 1 writes inv_window; cfg_ready is always high; the user keeps
//   writes to idle, which the block itself does not enforce
// - a taken request passes the product, the ring update and the low and high scaling
//   steps before out_valid rises; a new request is taken only once the previous result
//   has loaded; the single 26x22 multiplier runs three times per request
// - the ring is one 1024 x 32 memory, read when the request is taken, written next cycle
// - reset: window empty, window_length 256, inv_window 65536; no clearing pass, slots are
//   tracked by a high water mark, so the block takes requests right after reset
// - receiver stall: the result register holds; one further request can be taken and worked
//   up to the final step, where it waits until the held result is taken
module sliding_window_active_power
    import swap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // sample requests
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [15:0]      current_sample,
    input  logic signed [15:0]      voltage_sample,
    input  logic                    restart,
    // averaged results
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] average_power,
    output logic                    window_full
);

    dp_cmd_t cmd;
    logic    cfg_we;

    // config registers are always writable
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencing and handshakes
    swap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // ring, running sum, scaling
    swap_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .current_sample (current_sample),
        .voltage_sample (voltage_sample),
        .restart        (restart),
        .average_power  (average_power),
        .window_full    (window_full)
    );

endmodule
